// ----- rtl/mmtt_pkg.sv -----
package mmtt_pkg;

	localparam int TIME_BITS = 32;
	localparam int CNT_W     = $clog2(TIME_BITS);
	localparam int CFG_IDX_W = 3;

	localparam logic [2:0] MODE_DELAY_ON   = 3'd0;
	localparam logic [2:0] MODE_DELAY_OFF  = 3'd1;
	localparam logic [2:0] MODE_PULSE      = 3'd2;
	localparam logic [2:0] MODE_ONESHOT    = 3'd3;
	localparam logic [2:0] MODE_RETRIGGER  = 3'd4;
	localparam logic [2:0] MODE_MONOSTABLE = 3'd5;
	localparam logic [2:0] MODE_BLINK      = 3'd6;

	localparam logic [1:0] EDGE_LEVEL   = 2'd0;
	localparam logic [1:0] EDGE_RISING  = 2'd1;
	localparam logic [1:0] EDGE_FALLING = 2'd2;
	localparam logic [1:0] EDGE_BOTH    = 2'd3;

	localparam logic [1:0] REQ_UPDATE = 2'd0;
	localparam logic [1:0] REQ_PAUSE  = 2'd1;
	localparam logic [1:0] REQ_RESUME = 2'd2;
	localparam logic [1:0] REQ_RESET  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_EDGE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DURATION_MS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON_MS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_OFF_MS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RESET   = 3'd5;

	localparam logic [1:0] TSC_IDLE    = 2'd0;
	localparam logic [1:0] TSC_RUNNING = 2'd1;
	localparam logic [1:0] TSC_EXPIRED = 2'd2;
	localparam logic [1:0] TSC_PAUSED  = 2'd3;

	typedef enum logic [3:0] {
		TS_IDLE    = 4'b0001,
		TS_RUNNING = 4'b0010,
		TS_EXPIRED = 4'b0100,
		TS_PAUSED  = 4'b1000
	} tstate_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        trigger_active;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic        out_level;
		logic [1:0]  timer_state;
		logic [31:0] elapsed_time;
		logic [31:0] remaining_time;
	} rsp_t;

	function automatic logic [1:0] encode_state(tstate_t s);
		logic [1:0] code;
		unique case (s)
			TS_IDLE: code = TSC_IDLE;
			TS_RUNNING: code = TSC_RUNNING;
			TS_EXPIRED: code = TSC_EXPIRED;
			TS_PAUSED: code = TSC_PAUSED;
			default: code = TSC_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ----- rtl/multi_mode_trigger_timer_top.sv -----
// The engine takes one request at a time; the bit-serial subtractor runs two passes
// (elapsed time and resume stamp, then duration compare) and blink adds a 32-step remainder unit.
// A finished response waits in its own register, so the next request can be taken meanwhile.
// Reset is asynchronous and active low; it clears configuration and timer state to idle.
module multi_mode_trigger_timer_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_ready,
	input  mmtt_pkg::req_t                         req_data,
	output logic                                   rsp_valid,
	input  logic                                   rsp_ready,
	output mmtt_pkg::rsp_t                         rsp_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mmtt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [31:0]                            cfg_data
);
	import mmtt_pkg::*;

	typedef enum logic [6:0] {
		SQ_IDLE  = 7'b0000001,
		SQ_SUB   = 7'b0000010,
		SQ_APPLY = 7'b0000100,
		SQ_CMP   = 7'b0001000,
		SQ_DEC   = 7'b0010000,
		SQ_DIV   = 7'b0100000,
		SQ_DONE  = 7'b1000000
	} seq_t;

	seq_t                 seq_q;

	logic [2:0]           mode_q;
	logic [1:0]           edge_q;
	logic [31:0]          dur_q;
	logic [30:0]          on_q;
	logic [30:0]          off_q;
	logic                 auto_q;

	tstate_t              tstate_q;
	logic                 out_bit_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] pause_q;
	logic                 prev_q;

	logic [1:0]           req_type_q;
	logic                 trig_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 ev_q;
	logic                 run_upd_q;

	logic [TIME_BITS-1:0] a_q;
	logic [TIME_BITS-1:0] b_q;
	logic [TIME_BITS-1:0] c_q;
	logic [TIME_BITS-1:0] e_q;
	logic [TIME_BITS-1:0] s_q;
	logic                 br1_q;
	logic                 br2_q;
	logic                 cy_q;
	logic                 nz_q;
	logic [CNT_W-1:0]     cnt_q;

	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 req_fire;
	logic                 ev;
	logic                 e_bit;
	logic                 br1_nx;
	logic                 t_bit;
	logic                 br2_nx;
	logic                 s_bit;
	logic                 cy_nx;
	logic                 last_bit;
	logic                 clear_exp;
	logic                 retrig_hit;
	logic [TIME_BITS-1:0] elapsed_nx;
	logic [TIME_BITS-1:0] period;
	logic                 blink_stop;
	logic                 div_start;
	logic                 div_done;
	logic [TIME_BITS-1:0] div_rem;
	logic                 ge;
	logic                 rsp_load;
	logic [TIME_BITS-1:0] rem_val;

	assign req_ready = (seq_q == SQ_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		case (edge_q)
			EDGE_LEVEL: ev = req_data.trigger_active;
			EDGE_RISING: ev = req_data.trigger_active && !prev_q;
			EDGE_FALLING: ev = !req_data.trigger_active && prev_q;
			default: ev = req_data.trigger_active ^ prev_q;
		endcase
	end

	// Serial lanes: e = a - b, t = a - c, s = b + t, all least significant bit first.
	assign e_bit    = a_q[0] ^ b_q[0] ^ br1_q;
	assign br1_nx   = (!a_q[0] && b_q[0]) || (!(a_q[0] ^ b_q[0]) && br1_q);
	assign t_bit    = a_q[0] ^ c_q[0] ^ br2_q;
	assign br2_nx   = (!a_q[0] && c_q[0]) || (!(a_q[0] ^ c_q[0]) && br2_q);
	assign s_bit    = b_q[0] ^ t_bit ^ cy_q;
	assign cy_nx    = (b_q[0] && t_bit) || (cy_q && (b_q[0] ^ t_bit));
	assign last_bit = (cnt_q == CNT_W'(TIME_BITS - 1));

	assign clear_exp  = auto_q ? ((edge_q != EDGE_LEVEL) || !trig_q) : (mode_q == MODE_MONOSTABLE);
	assign retrig_hit = (mode_q == MODE_RETRIGGER) && ev_q;
	assign period     = TIME_BITS'({1'b0, on_q} + {1'b0, off_q});
	assign blink_stop = (edge_q == EDGE_LEVEL) && !trig_q;
	assign div_start  = (seq_q == SQ_DEC) && run_upd_q && (mode_q == MODE_BLINK) &&
		!blink_stop && (period != '0);
	assign ge         = br1_q || !nz_q;

	always_comb begin
		elapsed_nx = elapsed_q;
		case (req_type_q)
			REQ_UPDATE: begin
				unique case (tstate_q)
					TS_IDLE: begin
						if (ev_q) begin
							elapsed_nx = '0;
						end
					end
					TS_RUNNING: elapsed_nx = retrig_hit ? '0 : e_q;
					TS_EXPIRED: begin
						if (clear_exp) begin
							elapsed_nx = '0;
						end
					end
					default: ;
				endcase
			end
			REQ_RESET: elapsed_nx = '0;
			default: ;
		endcase
	end

	mmtt_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (elapsed_q),
		.divisor   (period),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign rsp_load = (seq_q == SQ_DONE) && (!rsp_valid_q || rsp_ready);
	assign rem_val  = ((tstate_q == TS_RUNNING) && !br1_q) ? e_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DELAY_ON;
			edge_q <= EDGE_LEVEL;
			dur_q  <= '0;
			on_q   <= '0;
			off_q  <= '0;
			auto_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TIMER_MODE: mode_q <= cfg_data[2:0];
				CFG_START_EDGE: edge_q <= cfg_data[1:0];
				CFG_DURATION_MS: dur_q <= cfg_data;
				CFG_BLINK_ON_MS: on_q <= cfg_data[30:0];
				CFG_BLINK_OFF_MS: off_q <= cfg_data[30:0];
				CFG_AUTO_RESET: auto_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= SQ_IDLE;
			tstate_q  <= TS_IDLE;
			out_bit_q <= 1'b0;
			elapsed_q <= '0;
			start_q   <= '0;
			pause_q   <= '0;
			prev_q    <= 1'b0;
			run_upd_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			unique case (seq_q)
				SQ_IDLE: begin
					if (req_fire) begin
						if (req_data.req_type == REQ_UPDATE) begin
							prev_q <= req_data.trigger_active;
						end
						cnt_q <= '0;
						seq_q <= SQ_SUB;
					end
				end
				SQ_SUB: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_bit) begin
						seq_q <= SQ_APPLY;
					end
				end
				SQ_APPLY: begin
					elapsed_q <= elapsed_nx;
					run_upd_q <= (req_type_q == REQ_UPDATE) && (tstate_q == TS_RUNNING);
					cnt_q     <= '0;
					seq_q     <= SQ_CMP;
					case (req_type_q)
						REQ_UPDATE: begin
							unique case (tstate_q)
								TS_IDLE: begin
									if (ev_q) begin
										tstate_q <= TS_RUNNING;
										start_q  <= now_q;
										if (mode_q == MODE_DELAY_ON) begin
											out_bit_q <= 1'b0;
										end else if (mode_q <= MODE_BLINK) begin
											out_bit_q <= 1'b1;
										end
									end
								end
								TS_RUNNING: begin
									if (retrig_hit) begin
										start_q <= now_q;
									end
								end
								TS_EXPIRED: begin
									if (clear_exp) begin
										tstate_q  <= TS_IDLE;
										out_bit_q <= 1'b0;
										start_q   <= '0;
									end
								end
								default: ;
							endcase
						end
						REQ_PAUSE: begin
							if (tstate_q == TS_RUNNING) begin
								pause_q  <= now_q;
								tstate_q <= TS_PAUSED;
							end
						end
						REQ_RESUME: begin
							if (tstate_q == TS_PAUSED) begin
								start_q  <= s_q;
								tstate_q <= TS_RUNNING;
							end
						end
						default: begin
							tstate_q  <= TS_IDLE;
							out_bit_q <= 1'b0;
							start_q   <= '0;
						end
					endcase
				end
				SQ_CMP: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_bit) begin
						seq_q <= SQ_DEC;
					end
				end
				SQ_DEC: begin
					if (run_upd_q && (mode_q == MODE_BLINK)) begin
						if (blink_stop) begin
							out_bit_q <= 1'b0;
							tstate_q  <= TS_IDLE;
							seq_q     <= SQ_DONE;
						end else if (period != '0) begin
							seq_q <= SQ_DIV;
						end else begin
							seq_q <= SQ_DONE;
						end
					end else begin
						if (run_upd_q && ge) begin
							if (mode_q == MODE_DELAY_ON) begin
								out_bit_q <= 1'b1;
								tstate_q  <= TS_EXPIRED;
							end else if (mode_q <= MODE_MONOSTABLE) begin
								out_bit_q <= 1'b0;
								tstate_q  <= TS_EXPIRED;
							end
						end
						seq_q <= SQ_DONE;
					end
				end
				SQ_DIV: begin
					if (div_done) begin
						out_bit_q <= (div_rem < TIME_BITS'(on_q));
						seq_q     <= SQ_DONE;
					end
				end
				SQ_DONE: begin
					if (rsp_load) begin
						seq_q <= SQ_IDLE;
					end
				end
				default: seq_q <= SQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_type_q <= req_data.req_type;
			trig_q     <= req_data.trigger_active;
			now_q      <= TIME_BITS'(req_data.now_ms);
			ev_q       <= ev;
			a_q        <= TIME_BITS'(req_data.now_ms);
			b_q        <= start_q;
			c_q        <= pause_q;
			br1_q      <= 1'b0;
			br2_q      <= 1'b0;
			cy_q       <= 1'b0;
		end else if (seq_q == SQ_SUB) begin
			a_q   <= a_q >> 1;
			b_q   <= b_q >> 1;
			c_q   <= c_q >> 1;
			e_q   <= {e_bit, e_q[TIME_BITS-1:1]};
			s_q   <= {s_bit, s_q[TIME_BITS-1:1]};
			br1_q <= br1_nx;
			br2_q <= br2_nx;
			cy_q  <= cy_nx;
		end else if (seq_q == SQ_APPLY) begin
			a_q   <= TIME_BITS'(dur_q);
			b_q   <= elapsed_nx;
			br1_q <= 1'b0;
			nz_q  <= 1'b0;
		end else if (seq_q == SQ_CMP) begin
			a_q   <= a_q >> 1;
			b_q   <= b_q >> 1;
			e_q   <= {e_bit, e_q[TIME_BITS-1:1]};
			br1_q <= br1_nx;
			nz_q  <= nz_q || e_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.out_level      <= out_bit_q;
			rsp_q.timer_state    <= encode_state(tstate_q);
			rsp_q.elapsed_time   <= 32'(elapsed_q);
			rsp_q.remaining_time <= 32'(rem_val);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ----- rtl/mmtt_rem.sv -----
module mmtt_rem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [mmtt_pkg::TIME_BITS-1:0] dividend,
	input  logic [mmtt_pkg::TIME_BITS-1:0] divisor,
	output logic                           done,
	output logic [mmtt_pkg::TIME_BITS-1:0] remainder
);
	import mmtt_pkg::*;

	logic [TIME_BITS-1:0] dvd_q;
	logic [TIME_BITS-1:0] dsr_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TIME_BITS:0]   trial;
	logic                 fits;

	// One restoring step per cycle: bring in the next dividend bit, subtract when it fits.
	assign trial = {rem_q, dvd_q[TIME_BITS-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(TIME_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
			if (fits) begin
				rem_q <= TIME_BITS'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[TIME_BITS-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/mmtt_check.sv -----
module mmtt_check (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input mmtt_pkg::rsp_t rsp_data
);
	import mmtt_pkg::*;

	// A stalled response beat holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response beat changed while stalled");

	// Only a running timer reports remaining time.
	a_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.timer_state != TSC_RUNNING) |-> rsp_data.remaining_time == 32'd0)
		else $error("remaining time reported outside running state");

	// An idle timer always drives its output low.
	a_idle_low: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.timer_state == TSC_IDLE) |-> !rsp_data.out_level)
		else $error("idle timer with output high");

	// The engine works on one request at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while engine busy");

endmodule

bind multi_mode_trigger_timer_top mmtt_check u_mmtt_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);
